// File: hw/rtl/asnap_pkg.sv
// Shared constants, register codes and stage payload types for the angle snap smoother.
// Depends on nothing; the design files refer to it by scoped names, the bench imports it.
package asnap_pkg;

	// Angle format: unsigned fixed point, ANGLE_FRAC_BITS fraction bits.
	localparam int ANGLE_FRAC_BITS = 4;
	localparam int SNAP_STEP       = 720;
	localparam int ANGLE_W         = 13;
	localparam int FULL_TURN       = 360 << ANGLE_FRAC_BITS;
	localparam int HALF_TURN       = 180 << ANGLE_FRAC_BITS;
	localparam int HALF_DEGREE     = (1 << ANGLE_FRAC_BITS) >> 1;

	// Configuration port.
	localparam int THR_W     = 10;
	localparam int GAIN_W    = 9;
	localparam int CFG_W     = 10;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_SNAP_THR   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_UNSNAP_THR = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN       = CFG_IDX_W'(2);

	localparam logic [THR_W-1:0]  SNAP_THR_RESET   = THR_W'(32);
	localparam logic [THR_W-1:0]  UNSNAP_THR_RESET = THR_W'(80);
	localparam logic [GAIN_W-1:0] GAIN_RESET       = GAIN_W'(51);

	// Gain is a fraction in 1/256.
	localparam int GAIN_FRAC  = 8;
	localparam int GAIN_ONE   = 1 << GAIN_FRAC;
	localparam int GAIN_ROUND = 1 << (GAIN_FRAC - 1);

	// Nearest snap point: floor((raw + step/2) / step) by an exact reciprocal.
	// Exact for every dividend below 2**ANGLE_W.
	localparam int RECIP_SHIFT = ANGLE_W + $clog2(SNAP_STEP);
	localparam int RECIP_MULT  = ((1 << RECIP_SHIFT) + SNAP_STEP - 1) / SNAP_STEP;
	localparam int PROD_W      = 2 * ANGLE_W + 1;
	localparam int QUOT_W      = $clog2(FULL_TURN / SNAP_STEP + 2);

	// Whole degrees, 0 to 360 inclusive.
	localparam int DEG_W     = 9;
	localparam int DEG_RIGHT = 90;
	localparam int DEG_TURN  = 360;
	localparam int DEG_Q1    = 45;
	localparam int DEG_Q2    = 135;
	localparam int DEG_Q3    = 225;
	localparam int DEG_Q4    = 315;

	typedef struct packed {
		logic              playing;
		logic [ANGLE_W-1:0] raw;
		logic [QUOT_W-1:0]  quot;
	} raw_item_t;

	typedef struct packed {
		logic              playing;
		logic              snapped;
		logic [ANGLE_W-1:0] target;
	} snap_item_t;

endpackage

// File: hw/rtl/asnap_raw_stage.sv
// First work stage: saturate the delta, advance the raw angle, find the snap quotient.
// Depends on asnap_pkg.
module asnap_raw_stage (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   load,
	input  logic signed [asnap_pkg::ANGLE_W-1:0]   delta,
	input  logic                                   playing,
	output asnap_pkg::raw_item_t                   item_s2
);

	localparam int SUM_W = asnap_pkg::ANGLE_W + 2;
	localparam logic signed [asnap_pkg::ANGLE_W-1:0] HALF_POS =
		asnap_pkg::ANGLE_W'(asnap_pkg::HALF_TURN);
	localparam logic signed [asnap_pkg::ANGLE_W-1:0] HALF_NEG =
		asnap_pkg::ANGLE_W'(-asnap_pkg::HALF_TURN);
	localparam logic signed [SUM_W-1:0] FULL_S = SUM_W'(asnap_pkg::FULL_TURN);

	logic [asnap_pkg::ANGLE_W-1:0]        raw_q;
	logic [asnap_pkg::ANGLE_W-1:0]        raw_new;
	logic signed [asnap_pkg::ANGLE_W-1:0] delta_sat;
	logic signed [SUM_W-1:0]              raw_sum;
	logic signed [SUM_W-1:0]              raw_wrap;
	logic [asnap_pkg::ANGLE_W-1:0]        snap_x;
	logic [asnap_pkg::PROD_W-1:0]         recip_prod;

	always_comb begin
		priority if (delta > HALF_POS) begin
			delta_sat = HALF_POS;
		end else if (delta < HALF_NEG) begin
			delta_sat = HALF_NEG;
		end else begin
			delta_sat = delta;
		end
		raw_sum = $signed({2'b00, raw_q}) - SUM_W'(delta_sat);
		priority if (raw_sum < 0) begin
			raw_wrap = raw_sum + FULL_S;
		end else if (raw_sum >= FULL_S) begin
			raw_wrap = raw_sum - FULL_S;
		end else begin
			raw_wrap = raw_sum;
		end
		raw_new    = raw_wrap[asnap_pkg::ANGLE_W-1:0];
		snap_x     = raw_new + asnap_pkg::ANGLE_W'(asnap_pkg::SNAP_STEP / 2);
		recip_prod = asnap_pkg::PROD_W'(snap_x)
			* asnap_pkg::PROD_W'(asnap_pkg::RECIP_MULT);
	end

	// Hold the raw angle through playback beats.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q <= '0;
		end else if (load && !playing) begin
			raw_q <= raw_new;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s2.playing <= playing;
			item_s2.raw     <= raw_new;
			item_s2.quot    <= recip_prod[asnap_pkg::RECIP_SHIFT +: asnap_pkg::QUOT_W];
		end
	end

endmodule

// File: hw/rtl/asnap_snap_stage.sv
// Second work stage: nearest snap point, distance and snap hysteresis; picks the target.
// Depends on asnap_pkg.
module asnap_snap_stage (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               load,
	input  asnap_pkg::raw_item_t               item_s2,
	input  logic [asnap_pkg::THR_W-1:0]        snap_thr,
	input  logic [asnap_pkg::THR_W-1:0]        unsnap_thr,
	output asnap_pkg::snap_item_t              item_s3
);

	logic                          snap_held_q;
	logic                          snap_new;
	logic [asnap_pkg::ANGLE_W-1:0] nearest;
	logic [asnap_pkg::ANGLE_W-1:0] snap_gap;

	always_comb begin
		nearest = asnap_pkg::ANGLE_W'(asnap_pkg::ANGLE_W'(item_s2.quot)
			* asnap_pkg::ANGLE_W'(asnap_pkg::SNAP_STEP));
		if (item_s2.raw >= nearest) begin
			snap_gap = item_s2.raw - nearest;
		end else begin
			snap_gap = nearest - item_s2.raw;
		end
		// Engage inside the snap threshold, stay engaged inside the unsnap threshold.
		if (snap_held_q) begin
			snap_new = snap_gap < asnap_pkg::ANGLE_W'(unsnap_thr);
		end else begin
			snap_new = snap_gap < asnap_pkg::ANGLE_W'(snap_thr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_held_q <= 1'b0;
		end else if (load && !item_s2.playing) begin
			snap_held_q <= snap_new;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s3.playing <= item_s2.playing;
			item_s3.snapped <= item_s2.playing ? snap_held_q : snap_new;
			item_s3.target  <= snap_new ? nearest : item_s2.raw;
		end
	end

endmodule

// File: hw/rtl/asnap_smooth_stage.sv
// Last work stage: move the smoothed angle a gain fraction of the shortest arc.
// Depends on asnap_pkg; its registers are the block's result register.
module asnap_smooth_stage (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           load,
	input  asnap_pkg::snap_item_t          item_s3,
	input  logic [asnap_pkg::GAIN_W-1:0]   gain,
	output logic [asnap_pkg::ANGLE_W-1:0]  smoothed_q,
	output logic                           snapped_q,
	output logic                           updated_q
);

	localparam int ARC_W = asnap_pkg::ANGLE_W + 2;
	localparam int PW    = ARC_W + asnap_pkg::GAIN_W + 1;
	localparam logic signed [ARC_W-1:0] FULL_A = ARC_W'(asnap_pkg::FULL_TURN);
	localparam logic signed [ARC_W-1:0] HALF_A = ARC_W'(asnap_pkg::HALF_TURN);
	localparam logic signed [PW-1:0]    FULL_P = PW'(asnap_pkg::FULL_TURN);

	logic signed [ARC_W-1:0]       arc_d;
	logic signed [ARC_W-1:0]       arc;
	logic [asnap_pkg::GAIN_W-1:0]  gain_eff;
	logic signed [PW-1:0]          prod;
	logic signed [PW-1:0]          step;
	logic signed [PW-1:0]          sm_sum;
	logic signed [PW-1:0]          sm_wrap;

	always_comb begin
		arc_d = $signed({2'b00, item_s3.target}) - $signed({2'b00, smoothed_q});
		// Shortest arc, half-open range from minus a half turn.
		priority if (arc_d >= HALF_A) begin
			arc = arc_d - FULL_A;
		end else if (arc_d < -HALF_A) begin
			arc = arc_d + FULL_A;
		end else begin
			arc = arc_d;
		end
		if (gain > asnap_pkg::GAIN_W'(asnap_pkg::GAIN_ONE)) begin
			gain_eff = asnap_pkg::GAIN_W'(asnap_pkg::GAIN_ONE);
		end else begin
			gain_eff = gain;
		end
		prod   = PW'(arc) * PW'($signed({1'b0, gain_eff}));
		step   = (prod + PW'(asnap_pkg::GAIN_ROUND)) >>> asnap_pkg::GAIN_FRAC;
		sm_sum = PW'($signed({1'b0, smoothed_q})) + step;
		priority if (sm_sum < 0) begin
			sm_wrap = sm_sum + FULL_P;
		end else if (sm_sum >= FULL_P) begin
			sm_wrap = sm_sum - FULL_P;
		end else begin
			sm_wrap = sm_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smoothed_q <= '0;
		end else if (load && !item_s3.playing) begin
			smoothed_q <= sm_wrap[asnap_pkg::ANGLE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			snapped_q <= item_s3.snapped;
			updated_q <= !item_s3.playing;
		end
	end

endmodule

// File: hw/rtl/asnap_orient.sv
// Orientation decode of the smoothed angle: right-angle flag and quadrant.
// Depends on asnap_pkg.
module asnap_orient (
	input  logic [asnap_pkg::ANGLE_W-1:0] angle,
	output logic                          line_smoothing,
	output logic [1:0]                    quadrant
);

	typedef enum logic [1:0] {
		QUAD_0DEG,
		QUAD_90DEG,
		QUAD_180DEG,
		QUAD_270DEG
	} quad_t;

	localparam int RIGHT_COUNT = asnap_pkg::DEG_TURN / asnap_pkg::DEG_RIGHT + 1;

	logic [asnap_pkg::ANGLE_W:0]    deg_sum;
	logic [asnap_pkg::DEG_W-1:0]    deg;
	logic                           on_right;
	quad_t                          quad;

	always_comb begin
		deg_sum = {1'b0, angle} + (asnap_pkg::ANGLE_W + 1)'(asnap_pkg::HALF_DEGREE);
		deg     = deg_sum[asnap_pkg::ANGLE_FRAC_BITS +: asnap_pkg::DEG_W];
		on_right = 1'b0;
		for (int k = 0; k < RIGHT_COUNT; k++) begin
			if (deg == asnap_pkg::DEG_W'(k * asnap_pkg::DEG_RIGHT)) begin
				on_right = 1'b1;
			end
		end
		priority if (deg < asnap_pkg::DEG_W'(asnap_pkg::DEG_Q1)
				|| deg >= asnap_pkg::DEG_W'(asnap_pkg::DEG_Q4)) begin
			quad = QUAD_0DEG;
		end else if (deg < asnap_pkg::DEG_W'(asnap_pkg::DEG_Q2)) begin
			quad = QUAD_90DEG;
		end else if (deg < asnap_pkg::DEG_W'(asnap_pkg::DEG_Q3)) begin
			quad = QUAD_180DEG;
		end else begin
			quad = QUAD_270DEG;
		end
	end

	assign line_smoothing = !on_right;
	assign quadrant       = quad;

endmodule

// File: hw/rtl/angle_snap_smoother_unit.sv
// Top level of the angle snap smoother: handshakes, configuration registers, input register.
// Depends on asnap_pkg, asnap_raw_stage, asnap_snap_stage, asnap_smooth_stage, asnap_orient.
//
// Takes one rotation beat per clock while out_ready holds and returns one result beat
// per input beat, in order. A beat is accepted into an input register, then passes three
// short stages: the raw stage subtracts the saturated delta from the raw angle (modulo
// a full turn) and finds the snap quotient by a constant reciprocal multiply; the snap
// stage forms the nearest snap point and applies the engage/release hysteresis; the
// smooth stage moves the smoothed angle by gain/256 (clamped to one) of the shortest
// arc with one 15x10 multiply and loads the result register. Each piece of state lives
// in the one stage that updates it, so items follow one another every cycle; sustained
// rate is one item per cycle while out_ready holds. Stages fill bubbles independently,
// so input beats keep being taken while a result waits, until every stage holds an item.
// A beat with playing set leaves all state untouched and reports the held state with
// updated low. Configuration writes take effect at once and are meant for an idle block.
module angle_snap_smoother_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [asnap_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [asnap_pkg::CFG_W-1:0]            cfg_wdata,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [asnap_pkg::ANGLE_W-1:0]   delta_angle,
	input  logic                                   playing,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [asnap_pkg::ANGLE_W-1:0]          camera_angle,
	output logic                                   snapped,
	output logic                                   line_smoothing,
	output logic [1:0]                             quadrant,
	output logic                                   updated
);

	// Configuration registers.
	logic [asnap_pkg::THR_W-1:0]  snap_thr_q;
	logic [asnap_pkg::THR_W-1:0]  unsnap_thr_q;
	logic [asnap_pkg::GAIN_W-1:0] gain_q;

	// Input register.
	logic                                 valid_s1;
	logic signed [asnap_pkg::ANGLE_W-1:0] delta_s1;
	logic                                 playing_s1;

	// Stage occupancy.
	logic valid_s2;
	logic valid_s3;
	logic out_valid_q;

	// Stage load strobes.
	logic load_out;
	logic load_s3;
	logic load_s2;
	logic load_s1;

	asnap_pkg::raw_item_t  item_s2;
	asnap_pkg::snap_item_t item_s3;

	// Each stage loads when its source holds a beat and it is empty or emptying.
	always_comb begin
		load_out = valid_s3 && (!out_valid_q || out_ready);
		load_s3  = valid_s2 && (!valid_s3 || load_out);
		load_s2  = valid_s1 && (!valid_s2 || load_s3);
		load_s1  = in_valid && (!valid_s1 || load_s2);
	end

	assign in_ready  = !valid_s1 || load_s2;
	assign out_valid = out_valid_q;

	// Register writes; drop writes to unknown indexes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_thr_q   <= asnap_pkg::SNAP_THR_RESET;
			unsnap_thr_q <= asnap_pkg::UNSNAP_THR_RESET;
			gain_q       <= asnap_pkg::GAIN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				asnap_pkg::CFG_SNAP_THR: begin
					snap_thr_q <= cfg_wdata[asnap_pkg::THR_W-1:0];
				end
				asnap_pkg::CFG_UNSNAP_THR: begin
					unsnap_thr_q <= cfg_wdata[asnap_pkg::THR_W-1:0];
				end
				asnap_pkg::CFG_GAIN: begin
					gain_q <= cfg_wdata[asnap_pkg::GAIN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Occupancy flags: set on load, clear when the beat moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= 1'b1;
			end else if (load_s2) begin
				valid_s1 <= 1'b0;
			end
			if (load_s2) begin
				valid_s2 <= 1'b1;
			end else if (load_s3) begin
				valid_s2 <= 1'b0;
			end
			if (load_s3) begin
				valid_s3 <= 1'b1;
			end else if (load_out) begin
				valid_s3 <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the input beat until the raw stage takes it.
	always_ff @(posedge clk) begin
		if (load_s1) begin
			delta_s1   <= delta_angle;
			playing_s1 <= playing;
		end
	end

	asnap_raw_stage u_raw (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (load_s2),
		.delta   (delta_s1),
		.playing (playing_s1),
		.item_s2 (item_s2)
	);

	asnap_snap_stage u_snap (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load_s3),
		.item_s2    (item_s2),
		.snap_thr   (snap_thr_q),
		.unsnap_thr (unsnap_thr_q),
		.item_s3    (item_s3)
	);

	// The smoothed-angle state doubles as the camera_angle result register.
	asnap_smooth_stage u_smooth (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load_out),
		.item_s3    (item_s3),
		.gain       (gain_q),
		.smoothed_q (camera_angle),
		.snapped_q  (snapped),
		.updated_q  (updated)
	);

	// Flags decode straight from the result register.
	asnap_orient u_orient (
		.angle          (camera_angle),
		.line_smoothing (line_smoothing),
		.quadrant       (quadrant)
	);

endmodule

// File: tb/angle_snap_smoother_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for angle_snap_smoother_unit: a directed table then random phases.
// Depends on asnap_pkg and the unit under test; results are checked against an in-bench model.
module angle_snap_smoother_unit_tb;
	import asnap_pkg::*;

	// Orientation codes as reported on the quadrant port.
	localparam logic [1:0] QUAD_0   = 2'd0;
	localparam logic [1:0] QUAD_90  = 2'd1;
	localparam logic [1:0] QUAD_180 = 2'd2;
	localparam logic [1:0] QUAD_270 = 2'd3;

	// Index with no register behind it; a write there must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(3);

	localparam int N_DIRECTED  = 20;
	localparam int N_PHASES    = 6;
	localparam int PHASE_BEATS = 125;
	localparam int IDLE_PCT    = 23;
	localparam int HOLD_CYCLES = 80;
	localparam int MAX_SHOWN   = 10;

	typedef struct packed {
		logic [ANGLE_W-1:0] camera;
		logic               snapped;
		logic               line_smooth;
		logic [1:0]         quad;
		logic               updated;
	} angle_report_t;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] delta;
		logic                      play;
		bit                        typed;
		angle_report_t             want;
	} stim_row_t;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [CFG_W-1:0]           cfg_wdata;
	logic                       in_valid;
	logic                       in_ready;
	logic signed [ANGLE_W-1:0]  delta_angle;
	logic                       playing;
	logic                       out_valid;
	logic                       out_ready;
	logic [ANGLE_W-1:0]         camera_angle;
	logic                       snapped;
	logic                       line_smoothing;
	logic [1:0]                 quadrant;
	logic                       updated;

	// Travels with the input beat: a hand-typed expectation overrides the model for that row.
	bit            row_typed;
	angle_report_t row_want;

	// Model copy of the configuration registers.
	logic [THR_W-1:0]  snap_thr;
	logic [THR_W-1:0]  unsnap_thr;
	logic [GAIN_W-1:0] gain_reg;

	// Model copy of the rotation state.
	logic [ANGLE_W-1:0] raw_pos;
	logic [ANGLE_W-1:0] smooth_pos;
	bit                 snap_hold;

	angle_report_t reports_due[$];
	int            fault_count;
	bit            idle_on;
	int            hold_asks;
	int            hold_seen;
	int            hold_left;

	stim_row_t directed_rows [N_DIRECTED];

	angle_snap_smoother_unit u_top (.*);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Advance the model by one accepted beat and return the report it must produce.
	// A playback beat leaves everything alone and just reports the held state.
	function automatic angle_report_t rotate_and_smooth(logic signed [ANGLE_W-1:0] delta_in,
			logic play);
		int            d;
		int            raw_i;
		int            near_pt;
		int            gap;
		int            goal;
		int            arc;
		int            g;
		int            step;
		int            sm;
		int            deg;
		angle_report_t r;
		if (!play) begin
			// Saturate the delta to half a turn either way.
			d = delta_in;
			if (d > HALF_TURN)
				d = HALF_TURN;
			if (d < -HALF_TURN)
				d = -HALF_TURN;
			raw_i = (int'(raw_pos) - d + FULL_TURN) % FULL_TURN;
			raw_pos = ANGLE_W'(raw_i);

			// Nearest snap point, ties rounding up; may land on a full turn.
			near_pt = ((raw_i + SNAP_STEP / 2) / SNAP_STEP) * SNAP_STEP;
			gap = raw_i - near_pt;
			if (gap < 0)
				gap = -gap;

			// Engage under one threshold, hold under the other, release otherwise.
			if (!snap_hold && gap < int'(snap_thr)) begin
				goal = near_pt;
				snap_hold = 1'b1;
			end else if (snap_hold && gap < int'(unsnap_thr)) begin
				goal = near_pt;
			end else begin
				goal = raw_i;
				snap_hold = 1'b0;
			end

			// Shortest signed arc, then a rounded fraction of it.
			arc = ((goal - int'(smooth_pos) + 3 * HALF_TURN) % FULL_TURN) - HALF_TURN;
			g = (int'(gain_reg) > GAIN_ONE) ? GAIN_ONE : int'(gain_reg);
			step = ((arc * g + HALF_TURN * GAIN_ONE + GAIN_ROUND) >>> GAIN_FRAC) - HALF_TURN;
			smooth_pos = ANGLE_W'((int'(smooth_pos) + step + FULL_TURN) % FULL_TURN);
		end

		sm = smooth_pos;
		deg = (sm + HALF_DEGREE) >> ANGLE_FRAC_BITS;
		r.camera = smooth_pos;
		r.snapped = snap_hold;
		r.line_smooth = (deg % DEG_RIGHT) != 0;
		if (deg < DEG_Q1 || deg >= DEG_Q4)
			r.quad = QUAD_0;
		else if (deg < DEG_Q2)
			r.quad = QUAD_90;
		else if (deg < DEG_Q3)
			r.quad = QUAD_180;
		else
			r.quad = QUAD_270;
		r.updated = !play;
		return r;
	endfunction

	// Mostly small moves so that snapping engages and releases; some wide, some raw noise.
	function automatic logic signed [ANGLE_W-1:0] pick_delta();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return ANGLE_W'(int'($urandom_range(0, 200)) - 100);
		else if (pick < 70)
			return ANGLE_W'(int'($urandom_range(0, 1440)) - 720);
		else if (pick < 88)
			return ANGLE_W'(int'($urandom_range(0, 2 * HALF_TURN)) - HALF_TURN);
		else
			return ANGLE_W'($urandom);
	endfunction

	task automatic log_fault(input string msg);
		fault_count++;
		if (fault_count <= MAX_SHOWN)
			$display("[%0t] %s", $realtime, msg);
	endtask

	// Offer one beat, with an optional random gap first; hold it until accepted.
	task automatic send_beat(input logic signed [ANGLE_W-1:0] d, input logic play,
			input bit typed, input angle_report_t want);
		while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		delta_angle <= d;
		playing <= play;
		row_typed <= typed;
		row_want <= want;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Drop valid and wait for every outstanding result, then let the pipe run dry.
	// Wait for a clock edge first so the beat taken on the last edge is already logged.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (reports_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write all three registers plus a stray write to the unused index.
	// Only ever called with the block idle, so the model may take the values at once.
	task automatic program_regs(input int snap_v, input int unsnap_v, input int gain_v);
		cfg_we <= 1'b1;
		cfg_index <= CFG_SNAP_THR;
		cfg_wdata <= CFG_W'(snap_v);
		@(posedge clk);
		cfg_index <= CFG_UNSNAP_THR;
		cfg_wdata <= CFG_W'(unsnap_v);
		@(posedge clk);
		cfg_index <= CFG_GAIN;
		cfg_wdata <= CFG_W'(gain_v);
		@(posedge clk);
		cfg_index <= CFG_UNUSED;
		cfg_wdata <= CFG_W'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		snap_thr = THR_W'(snap_v);
		unsnap_thr = THR_W'(unsnap_v);
		gain_reg = GAIN_W'(gain_v);
	endtask

	// Receiver: random back-pressure, a calm phase with none, and on request one long
	// hold-off so the pipe fills up and the input side has to stall.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			out_ready <= 1'b0;
		end else if (hold_seen != hold_asks) begin
			hold_seen = hold_asks;
			hold_left = HOLD_CYCLES - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= !idle_on || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// Scoreboard: retire a result beat against the oldest expectation, then log any
	// input beat taken on the same edge. Latency keeps the two from ever colliding.
	always @(posedge clk) begin : watch_beats
		angle_report_t got;
		angle_report_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = '{camera_angle, snapped, line_smoothing, quadrant, updated};
				if (reports_due.size() == 0) begin
					log_fault("result beat with nothing pending");
				end else begin
					want = reports_due.pop_front();
					if (got !== want)
						log_fault($sformatf({"mismatch: want angle %0d snap %0b line %0b ",
							"quad %0d upd %0b, got angle %0d snap %0b line %0b quad %0d upd %0b"},
							want.camera, want.snapped, want.line_smooth, want.quad,
							want.updated, got.camera, got.snapped, got.line_smooth, got.quad,
							got.updated));
				end
			end
			if (in_valid && in_ready) begin
				want = rotate_and_smooth(delta_angle, playing);
				reports_due.push_back(row_typed ? row_want : want);
			end
		end
	end

	initial begin
		int p;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_SNAP_THR;
		cfg_wdata = '0;
		in_valid = 1'b0;
		delta_angle = '0;
		playing = 1'b0;
		out_ready = 1'b0;
		row_typed = 1'b0;
		row_want = '0;
		snap_thr = SNAP_THR_RESET;
		unsnap_thr = UNSNAP_THR_RESET;
		gain_reg = GAIN_RESET;
		raw_pos = '0;
		smooth_pos = '0;
		snap_hold = 1'b0;
		fault_count = 0;
		idle_on = 1'b1;
		hold_asks = 0;
		hold_seen = 0;
		hold_left = 0;

		// Directed rows run on the reset register values. The first two are read straight
		// off the reset state; the rest hit the delta extremes, saturation just past half a
		// turn, a slow drift that releases a snap, re-engagement, a tie between snap points
		// and playback beats in the middle of a moving state.
		directed_rows = '{
			'{ANGLE_W'(-1),    1'b1, 1'b1, '{ANGLE_W'(0), 1'b0, 1'b0, QUAD_0, 1'b0}},
			'{ANGLE_W'(0),     1'b0, 1'b1, '{ANGLE_W'(0), 1'b1, 1'b0, QUAD_0, 1'b1}},
			'{ANGLE_W'(4095),  1'b0, 1'b0, '0},
			'{ANGLE_W'(-4096), 1'b0, 1'b0, '0},
			'{ANGLE_W'(2880),  1'b0, 1'b0, '0},
			'{ANGLE_W'(-2880), 1'b0, 1'b0, '0},
			'{ANGLE_W'(2881),  1'b0, 1'b0, '0},
			'{ANGLE_W'(-2881), 1'b0, 1'b0, '0},
			'{ANGLE_W'(20),    1'b0, 1'b0, '0},
			'{ANGLE_W'(20),    1'b0, 1'b0, '0},
			'{ANGLE_W'(20),    1'b0, 1'b0, '0},
			'{ANGLE_W'(20),    1'b0, 1'b0, '0},
			'{ANGLE_W'(20),    1'b0, 1'b0, '0},
			'{ANGLE_W'(-100),  1'b0, 1'b0, '0},
			'{ANGLE_W'(1234),  1'b1, 1'b0, '0},
			'{ANGLE_W'(-1),    1'b0, 1'b0, '0},
			'{ANGLE_W'(1),     1'b0, 1'b0, '0},
			'{ANGLE_W'(360),   1'b0, 1'b0, '0},
			'{ANGLE_W'(-4096), 1'b1, 1'b0, '0},
			'{ANGLE_W'(-720),  1'b0, 1'b0, '0}
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			send_beat(directed_rows[i].delta, directed_rows[i].play, directed_rows[i].typed,
				directed_rows[i].want);
		settle();

		// Random phases, each on its own register setting:
		//   zero thresholds and gain (never snaps, never moves), all-ones writes (gain
		//   clamps to one), snap-step thresholds at unit gain with no idling anywhere, the
		//   reset values under a long receiver hold-off, then two random settings.
		for (p = 0; p < N_PHASES; p++) begin
			case (p)
				0: program_regs(0, 0, 0);
				1: program_regs(1023, 1023, 1023);
				2: program_regs(720, 720, GAIN_ONE);
				3: program_regs(SNAP_THR_RESET, UNSNAP_THR_RESET, GAIN_RESET);
				4: program_regs($urandom_range(0, 200), $urandom_range(0, 200),
					$urandom_range(1, GAIN_ONE - 1));
				default: program_regs($urandom_range(0, 1023), $urandom_range(0, 1023),
					$urandom_range(0, 1023));
			endcase
			idle_on = (p != 2);
			if (p == 3)
				hold_asks++;
			repeat (PHASE_BEATS)
				send_beat(pick_delta(), $urandom_range(0, 99) < 8, 1'b0, '0);
			settle();
		end

		repeat (8) @(posedge clk);
		if (fault_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

endmodule

// File: files.f
hw/rtl/asnap_pkg.sv
hw/rtl/asnap_raw_stage.sv
hw/rtl/asnap_snap_stage.sv
hw/rtl/asnap_smooth_stage.sv
hw/rtl/asnap_orient.sv
hw/rtl/angle_snap_smoother_unit.sv
tb/angle_snap_smoother_unit_tb.sv
